// File: hdl/u8s_pkg.sv
// u8s_pkg: shared types and constants for the UTF-8 sanitizer.
// Holds the front-to-back request format and queue sizing; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package u8s_pkg;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [20:0] MIN_LEN2  = 21'h000080;
  localparam logic [20:0] MIN_LEN3  = 21'h000800;
  localparam logic [20:0] MIN_LEN4  = 21'h010000;
  localparam logic [20:0] CODE_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // replacement character U+FFFD, bytes in order
  localparam logic [2:0][7:0] REPL_BYTES = {8'hBD, 8'hBF, 8'hEF};
  localparam logic [1:0]      REPL_LAST  = 2'd2;

  // one request: up to four units, each a literal byte or a replacement
  typedef struct packed {
    logic [3:0][7:0] unit_byte;
    logic [3:0]      unit_repl;
    logic [1:0]      last_unit;
    logic            text_end;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/u8s_front.sv
// u8s_front: accepts input bytes, tracks the pending sequence and issues
// output requests. Depends on u8s_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8s_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          text_end,
  output u8s_pkg::cmd_t      cmd,
  output logic               cmd_push
);
  import u8s_pkg::*;

  logic [2:0][7:0] held_bytes;
  logic [1:0]      held_count, held_count_next;
  logic [2:0]      seq_length, seq_length_next;
  logic [20:0]     code_accum, code_accum_next;

  logic            hold_we;
  logic [1:0]      hold_idx;
  logic            push_c;

  logic            is_cont, is_ascii, lead_hold, complete, seq_ok;
  logic [2:0]      lead_len;
  logic [20:0]     lead_bits, acc_n, minimum;

  always_comb begin
    lead_len  = 3'd0;
    lead_bits = 21'd0;
    if (in_byte[7:5] == 3'b110) begin
      lead_len  = SEQ_LEN2;
      lead_bits = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_len  = SEQ_LEN3;
      lead_bits = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_len  = SEQ_LEN4;
      lead_bits = {18'd0, in_byte[2:0]};
    end
  end

  assign is_cont   = (in_byte[7:6] == 2'b10);
  assign is_ascii  = ~in_byte[7];
  assign lead_hold = ~is_ascii && (lead_len != 3'd0) && ~text_end;
  assign acc_n     = {code_accum[14:0], in_byte[5:0]};
  assign complete  = ({1'b0, held_count} + 3'd1) >= seq_length;

  always_comb begin
    unique case (seq_length)
      SEQ_LEN2: minimum = MIN_LEN2;
      SEQ_LEN3: minimum = MIN_LEN3;
      default:  minimum = MIN_LEN4;
    endcase
  end

  assign seq_ok = (acc_n >= minimum) && (acc_n <= CODE_MAX) &&
                  ((acc_n < SURR_LO) || (acc_n > SURR_HI));

  always_comb begin
    held_count_next = held_count;
    seq_length_next = seq_length;
    code_accum_next = code_accum;
    hold_we         = 1'b0;
    hold_idx        = 2'd0;
    push_c          = 1'b0;
    cmd.unit_byte   = {in_byte, held_bytes[2], held_bytes[1], held_bytes[0]};
    cmd.unit_byte[held_count] = in_byte;
    cmd.unit_repl   = 4'b1111;
    cmd.last_unit   = held_count;
    cmd.text_end    = text_end;

    if (held_count == 2'd0) begin
      if (is_ascii) begin
        cmd.unit_repl[0] = 1'b0;
        push_c = 1'b1;
      end else if (lead_hold) begin
        hold_we         = 1'b1;
        held_count_next = 2'd1;
        seq_length_next = lead_len;
        code_accum_next = lead_bits;
      end else begin
        push_c = 1'b1;
      end
    end else if (is_cont) begin
      if (complete) begin
        cmd.unit_repl   = {4{~seq_ok}};
        push_c          = 1'b1;
        held_count_next = 2'd0;
        seq_length_next = 3'd0;
        code_accum_next = 21'd0;
      end else if (text_end || held_count == 2'd3) begin
        push_c          = 1'b1;
        held_count_next = 2'd0;
        seq_length_next = 3'd0;
        code_accum_next = 21'd0;
      end else begin
        hold_we         = 1'b1;
        hold_idx        = held_count;
        held_count_next = held_count + 2'd1;
        code_accum_next = acc_n;
      end
    end else begin
      // broken sequence: held bytes become replacements; a lead restarts
      push_c = 1'b1;
      if (is_ascii) begin
        cmd.unit_repl[held_count] = 1'b0;
        held_count_next = 2'd0;
        seq_length_next = 3'd0;
        code_accum_next = 21'd0;
      end else if (lead_hold) begin
        cmd.last_unit   = held_count - 2'd1;
        hold_we         = 1'b1;
        held_count_next = 2'd1;
        seq_length_next = lead_len;
        code_accum_next = lead_bits;
      end else begin
        held_count_next = 2'd0;
        seq_length_next = 3'd0;
        code_accum_next = 21'd0;
      end
    end
  end

  assign cmd_push = accept && push_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_length <= 3'd0;
      code_accum <= 21'd0;
    end else if (accept) begin
      held_count <= held_count_next;
      seq_length <= seq_length_next;
      code_accum <= code_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held_bytes[hold_idx] <= in_byte;
    end
  end

endmodule
`default_nettype wire

// File: hdl/u8s_queue.sv
// u8s_queue: short request queue between front and back.
// Depends on u8s_pkg for the request type and depth.
`timescale 1ns / 1ps
`default_nettype none
module u8s_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  u8s_pkg::cmd_t      wr_data,
  output logic               full,
  input  wire logic          rd,
  output u8s_pkg::cmd_t      rd_data,
  output logic               empty
);
  import u8s_pkg::*;

  cmd_t             slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [Q_CW-1:0]  count;
  logic             do_wr, do_rd;

  assign full    = (count == Q_CW'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && ~full;
  assign do_rd   = rd && ~empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      end
      if (do_wr && ~do_rd) begin
        count <= count + Q_CW'(1);
      end else if (do_rd && ~do_wr) begin
        count <= count - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/u8s_back.sv
// u8s_back: expands queued requests into output bytes, one per cycle while pop is high.
// Depends on u8s_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8s_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  u8s_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               text_last,
  output logic               empty,
  input  wire logic          pop
);
  import u8s_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] unit;
  logic [1:0] sub;
  logic       unit_done, advance, load;

  assign unit_done = cur.unit_repl[unit] ? (sub == REPL_LAST) : 1'b1;
  assign run_last  = cur_valid && unit_done && (unit == cur.last_unit);
  assign text_last = run_last && cur.text_end;
  assign out_byte  = cur.unit_repl[unit] ? REPL_BYTES[sub] : cur.unit_byte[unit];
  assign empty     = ~cur_valid;
  assign advance   = pop && cur_valid;
  assign load      = (~cur_valid || (advance && run_last)) && ~q_empty;
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      unit      <= 2'd0;
      sub       <= 2'd0;
    end else if (load) begin
      cur_valid <= 1'b1;
      unit      <= 2'd0;
      sub       <= 2'd0;
    end else if (advance) begin
      if (run_last) begin
        cur_valid <= 1'b0;
      end else if (unit_done) begin
        unit <= unit + 2'd1;
        sub  <= 2'd0;
      end else begin
        sub <= sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/utf8_sanitizer.sv
// utf8_sanitizer: top level; one byte in per cycle while not full, sanitized UTF-8 out.
// With an idle back end, a request is written into the queue and then loaded into the
// output stage, after which its first byte is visible.
// Input rate is one byte per cycle while the four-entry request queue has room;
// output is one byte per cycle while pop is high; a request stays until its last byte.
// Synchronous reset clears the pending sequence, the queue and the output stage.
// Depends on u8s_pkg, u8s_front, u8s_queue, u8s_back.
`timescale 1ns / 1ps
`default_nettype none
module utf8_sanitizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       text_end,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            text_last
);
  import u8s_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_push, q_empty, q_pop, accept;

  assign accept = push && ~full;

  u8s_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .text_end (text_end),
    .cmd      (f_cmd),
    .cmd_push (f_push)
  );

  u8s_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_cmd),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  u8s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_cmd),
    .q_pop     (q_pop),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_last (text_last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire
